// ===== rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int WORD_BITS = 32;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] in_r0c0;
		logic signed [WORD_BITS-1:0] in_r0c1;
		logic signed [WORD_BITS-1:0] in_r0c2;
		logic signed [WORD_BITS-1:0] in_r1c0;
		logic signed [WORD_BITS-1:0] in_r1c1;
		logic signed [WORD_BITS-1:0] in_r1c2;
		logic signed [WORD_BITS-1:0] in_r2c0;
		logic signed [WORD_BITS-1:0] in_r2c1;
		logic signed [WORD_BITS-1:0] in_r2c2;
	} matrix_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] out_r0c0;
		logic signed [WORD_BITS-1:0] out_r0c1;
		logic signed [WORD_BITS-1:0] out_r0c2;
		logic signed [WORD_BITS-1:0] out_r1c0;
		logic signed [WORD_BITS-1:0] out_r1c1;
		logic signed [WORD_BITS-1:0] out_r1c2;
		logic signed [WORD_BITS-1:0] out_r2c0;
		logic signed [WORD_BITS-1:0] out_r2c1;
		logic signed [WORD_BITS-1:0] out_r2c2;
		logic                        singular;
		logic                        saturated;
	} inverse_t;

	typedef struct packed {
		logic valid;
		logic singular;
		logic saturated;
	} lane_stat_t;

endpackage

// ===== rtl/m3i_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Cofactor and determinant pipeline: nine 2x2 minors with checkerboard signs,
// then expansion along row 0 with split partial products.
// ----------------------------------------------------------------------------
module m3i_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid,
	input  m3i_pkg::matrix_t                       mat,
	output logic signed [2*m3i_pkg::WORD_BITS:0]   cof [0:8],
	output logic signed [3*m3i_pkg::WORD_BITS:0]   det,
	output logic                                   det_valid
);

	localparam int W  = m3i_pkg::WORD_BITS;
	localparam int CW = 2*W + 1;
	localparam int DW = 3*W + 1;

	logic signed [W-1:0]    a [0:8];
	logic signed [2*W-1:0]  pa_s1 [0:8];
	logic signed [2*W-1:0]  pb_s1 [0:8];
	logic signed [W-1:0]    a0_s1 [0:2];
	logic signed [W-1:0]    a0_s2 [0:2];
	logic signed [CW-1:0]   cof_s2 [0:8];
	logic signed [CW-1:0]   cof_s3 [0:8];
	logic signed [CW-1:0]   cof_s4 [0:8];
	logic signed [CW-1:0]   cof_s5 [0:8];
	logic signed [2*W:0]    pl_s3 [0:2];
	logic signed [2*W:0]    ph_s3 [0:2];
	logic signed [DW-1:0]   t_s4 [0:2];
	logic signed [DW-1:0]   det_s5;
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;

	assign a[0] = mat.in_r0c0;
	assign a[1] = mat.in_r0c1;
	assign a[2] = mat.in_r0c2;
	assign a[3] = mat.in_r1c0;
	assign a[4] = mat.in_r1c1;
	assign a[5] = mat.in_r1c2;
	assign a[6] = mat.in_r2c0;
	assign a[7] = mat.in_r2c1;
	assign a[8] = mat.in_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	genvar k;
	generate
		for (k = 0; k < 9; k++) begin : g_minor
			localparam int R   = k / 3;
			localparam int C   = k % 3;
			localparam int R1  = (R == 0) ? 1 : 0;
			localparam int R2  = (R == 2) ? 1 : 2;
			localparam int C1  = (C == 0) ? 1 : 0;
			localparam int C2  = (C == 2) ? 1 : 2;
			localparam bit NEG = ((R + C) % 2) == 1;
			logic signed [CW-1:0] diff;

			assign diff = CW'(pa_s1[k]) - CW'(pb_s1[k]);

			always_ff @(posedge clk) begin
				pa_s1[k]  <= a[R1*3+C1] * a[R2*3+C2];
				pb_s1[k]  <= a[R1*3+C2] * a[R2*3+C1];
				cof_s2[k] <= NEG ? -diff : diff;
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
			end
		end

		for (k = 0; k < 3; k++) begin : g_row0
			always_ff @(posedge clk) begin
				a0_s1[k] <= a[k];
				a0_s2[k] <= a0_s1[k];
				pl_s3[k] <= a0_s2[k] * $signed({1'b0, cof_s2[k][W-1:0]});
				ph_s3[k] <= a0_s2[k] * $signed(cof_s2[k][CW-1:W]);
				t_s4[k]  <= (DW'(ph_s3[k]) <<< W) + DW'(pl_s3[k]);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
	end

	assign cof       = cof_s5;
	assign det       = det_s5;
	assign det_valid = v_s5;

endmodule

// ===== rtl/m3i_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_lane
// One output element: cofactor over determinant, rounded half away from
// zero, by a bit-per-stage restoring divider, then saturation.
// ----------------------------------------------------------------------------
module m3i_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid,
	input  logic signed [2*m3i_pkg::WORD_BITS:0]   cof,
	input  logic signed [3*m3i_pkg::WORD_BITS:0]   det,
	output logic signed [m3i_pkg::WORD_BITS-1:0]   value,
	output m3i_pkg::lane_stat_t                    stat
);

	localparam int W   = m3i_pkg::WORD_BITS;
	localparam int CW  = 2*W + 1;
	localparam int DW  = 3*W + 1;
	localparam int QB  = W + 1;
	localparam int NW0 = 2*W + 2*FRAC_BITS + 1;
	localparam int NW1 = (NW0 > DW + QB + 1) ? NW0 : DW + QB + 1;
	localparam int XW  = NW1 + 1;
	localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (W-1)) - 64'd1);
	localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (W-1));

	logic [CW-1:0] cmag;
	logic [DW-1:0] dmag;

	logic [XW-1:0] rem_s [0:QB+1];
	logic [DW:0]   d_s   [0:QB+1];
	logic [QB-1:0] q_s   [0:QB+1];
	logic          neg_s [0:QB+1];
	logic          zero_s[0:QB+1];
	logic          big_s [0:QB+1];
	logic          v_s   [0:QB+1];

	logic signed [W-1:0] value_q;
	logic                valid_q;
	logic                sing_q;
	logic                sat_q;

	assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);
	assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= (XW'(cmag) << (2*FRAC_BITS + 1)) + XW'(dmag);
		d_s[0]    <= {dmag, 1'b0};
		q_s[0]    <= '0;
		neg_s[0]  <= cof[CW-1] ^ det[DW-1];
		zero_s[0] <= (det == '0);
		big_s[0]  <= 1'b0;
	end

	genvar k;
	generate
		for (k = 1; k <= QB + 1; k++) begin : g_step
			logic [XW-1:0] dsh;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else begin
					v_s[k] <= v_s[k-1];
				end
			end

			if (k == 1) begin : g_ovf
				assign dsh = XW'(d_s[0]) << QB;
				always_ff @(posedge clk) begin
					rem_s[1] <= rem_s[0];
					q_s[1]   <= q_s[0];
					big_s[1] <= (rem_s[0] >= dsh);
				end
			end else begin : g_bit
				localparam int B = QB + 1 - k;
				assign dsh = XW'(d_s[k-1]) << B;
				always_ff @(posedge clk) begin
					big_s[k] <= big_s[k-1];
					if (rem_s[k-1] >= dsh) begin
						rem_s[k] <= rem_s[k-1] - dsh;
						q_s[k]   <= q_s[k-1] | (QB'(1) << B);
					end else begin
						rem_s[k] <= rem_s[k-1];
						q_s[k]   <= q_s[k-1];
					end
				end
			end

			always_ff @(posedge clk) begin
				d_s[k]    <= d_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end
	endgenerate

	logic [QB-1:0] qf;
	logic [W-1:0]  qn;
	assign qf = q_s[QB+1];
	assign qn = W'(0) - qf[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= v_s[QB+1];
		end
	end

	always_ff @(posedge clk) begin
		sing_q <= zero_s[QB+1];
		if (zero_s[QB+1]) begin
			value_q <= '0;
			sat_q   <= 1'b0;
		end else if (neg_s[QB+1]) begin
			if (big_s[QB+1] || qf > NEG_LIM) begin
				value_q <= $signed(NEG_LIM[W-1:0]);
				sat_q   <= 1'b1;
			end else begin
				value_q <= $signed(qn);
				sat_q   <= 1'b0;
			end
		end else begin
			if (big_s[QB+1] || qf > POS_LIM) begin
				value_q <= $signed(POS_LIM[W-1:0]);
				sat_q   <= 1'b1;
			end else begin
				value_q <= $signed(qf[W-1:0]);
				sat_q   <= 1'b0;
			end
		end
	end

	assign value = value_q;
	assign stat  = '{valid: valid_q, singular: sing_q, saturated: sat_q};

endmodule

// ===== rtl/matrix3_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 signed fixed-point matrix inverse via transposed adjugate over det.
// ----------------------------------------------------------------------------
// Takes one matrix per clock (busy is always low) and returns its inverse
// with done high for exactly one cycle; the result
// is not held and must be captured when done is high. The path runs through
// the cofactor and determinant pipeline, then per element a restoring divider
// (a setup stage with the rounding bias, one quotient bit per stage plus an
// overflow check), the sign/saturation register and the output register.
// Zero determinant gives singular with zero elements; any clipped element sets saturated.
module matrix3_inverse #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  m3i_pkg::matrix_t   request,
	output logic               done,
	output m3i_pkg::inverse_t  result
);

	localparam int W  = m3i_pkg::WORD_BITS;
	localparam int CW = 2*W + 1;
	localparam int DW = 3*W + 1;

	logic signed [CW-1:0] cof [0:8];
	logic signed [DW-1:0] det;
	logic                 det_valid;
	logic signed [W-1:0]  lane_val [0:8];
	m3i_pkg::lane_stat_t  lane_stat [0:8];
	logic [8:0]           lane_valid;
	logic [8:0]           lane_sing;
	logic [8:0]           lane_sat;

	logic                 done_q;
	m3i_pkg::inverse_t    result_q;

	assign busy = 1'b0;

	m3i_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (start),
		.mat       (request),
		.cof       (cof),
		.det       (det),
		.det_valid (det_valid)
	);

	genvar k;
	generate
		for (k = 0; k < 9; k++) begin : g_lane
			localparam int I = k / 3;
			localparam int J = k % 3;
			m3i_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.valid  (det_valid),
				.cof    (cof[J*3+I]),
				.det    (det),
				.value  (lane_val[k]),
				.stat   (lane_stat[k])
			);
			assign lane_valid[k] = lane_stat[k].valid;
			assign lane_sing[k]  = lane_stat[k].singular;
			assign lane_sat[k]   = lane_stat[k].saturated;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lane_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_r0c0  <= lane_val[0];
		result_q.out_r0c1  <= lane_val[1];
		result_q.out_r0c2  <= lane_val[2];
		result_q.out_r1c0  <= lane_val[3];
		result_q.out_r1c1  <= lane_val[4];
		result_q.out_r1c2  <= lane_val[5];
		result_q.out_r2c0  <= lane_val[6];
		result_q.out_r2c1  <= lane_val[7];
		result_q.out_r2c2  <= lane_val[8];
		result_q.singular  <= |lane_sing;
		result_q.saturated <= |lane_sat;
	end

	assign done   = done_q;
	assign result = result_q;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_valid == 9'h000) || (lane_valid == 9'h1ff))
		else $error("lanes out of step");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.singular) |-> (!result.saturated && result.out_r0c0 == '0
			&& result.out_r1c1 == '0 && result.out_r2c2 == '0 && result.out_r0c2 == '0))
		else $error("singular result not cleared");

	a_done_follows_lane: assert property (@(posedge clk) disable iff (!arst_n)
		lane_valid[0] |=> done)
		else $error("lane result dropped");

endmodule
